### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked property checks with an active-low asynchronous reset guard.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent holds in the same cycle as the consequent
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// consequent is checked in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/rrft_pkg.sv
// ----------------------------------------------------------------------------
// rrft_pkg
// Shared constants and register codes of the ray frame transform unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rrft_pkg;

	localparam int WORD_W     = 32;
	localparam int CFG_DATA_W = 64;
	localparam int CFG_ADDR_W = 6;

	localparam logic CMD_FWD = 1'b0;
	localparam logic CMD_REV = 1'b1;

	typedef enum logic [2:0] {
		REG_ROT_ROW0 = 3'd0,
		REG_ROT_ROW1 = 3'd1,
		REG_ROT_ROW2 = 3'd2,
		REG_OFFSET_X = 3'd3,
		REG_OFFSET_Y = 3'd4,
		REG_OFFSET_Z = 3'd5
	} reg_idx_t;

endpackage

`default_nettype wire

### hdl/ray_rigid_frame_transform_unit.sv
// ----------------------------------------------------------------------------
// ray_rigid_frame_transform_unit
// Maps rays between two frames with a configured rotation and offset.
// ----------------------------------------------------------------------------
// Usage:
//   Rays arrive on the s_t* stream; s_tuser selects forward (into the
//   destination frame, R^T * (p - offset)) or reverse (R * p + offset).
//   Transformed rays leave on the m_t* stream, one item per input item, in
//   order. A failed ray keeps its position and direction.
//   The rotation rows and the offset are set through the APB port at byte
//   addresses 0x00..0x28 in steps of 8; write them only while the stream
//   is empty.
//   An accepted item passes four registered stages to the result handshake:
//   operand setup, eighteen parallel multiplies, three-term sum with
//   rounding, then offset add and saturation into the output register.
//   Throughput is one item per cycle while m_tready is high, set by the pipeline.
//   Reset empties all stages and loads the default rotation and a zero
//   offset. When m_tready is low the output item holds, the earlier stages
//   keep filling, and s_tready drops once all four stages are occupied.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ray_rigid_frame_transform_unit #(
	parameter int POS_WIDTH = 32,
	parameter int DIR_WIDTH = 24,
	parameter int ROT_WIDTH = 18
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	// cmd
	input  wire logic                                   s_tuser,
	input  wire logic                                   s_tvalid,
	output logic                                        s_tready,
	// pos_x, pos_y, pos_z, dir_x, dir_y, dir_z, ray_time, wave_len,
	// vignetted, failed_in, zero fill
	input  wire logic [((6*POS_WIDTH/2+3*DIR_WIDTH+2*rrft_pkg::WORD_W+2+7)/8)*8-1:0] s_tdata,
	output logic                                        m_tvalid,
	input  wire logic                                   m_tready,
	// out_pos_x, out_pos_y, out_pos_z, out_dir_x, out_dir_y, out_dir_z,
	// out_time, out_wave, out_vignetted, out_failed, zero fill
	output logic [((6*POS_WIDTH/2+3*DIR_WIDTH+2*rrft_pkg::WORD_W+2+7)/8)*8-1:0] m_tdata,
	input  wire logic                                   psel,
	input  wire logic                                   penable,
	input  wire logic                                   pwrite,
	input  wire logic [rrft_pkg::CFG_ADDR_W-1:0]        paddr,
	input  wire logic [rrft_pkg::CFG_DATA_W-1:0]        pwdata,
	output logic [rrft_pkg::CFG_DATA_W-1:0]             prdata,
	output logic                                        pready
);

	localparam int WW      = rrft_pkg::WORD_W;
	localparam int PX_LO   = 0;
	localparam int DX_LO   = 3*POS_WIDTH;
	localparam int TM_LO   = DX_LO + 3*DIR_WIDTH;
	localparam int WV_LO   = TM_LO + WW;
	localparam int VG_BIT  = WV_LO + WW;
	localparam int FL_BIT  = VG_BIT + 1;
	localparam int PAY_W   = FL_BIT + 1;
	localparam int TD_W    = ((PAY_W + 7) / 8) * 8;
	localparam int ROWW    = 3*ROT_WIDTH;
	localparam int FRAC    = ROT_WIDTH - 2;
	localparam int AW      = POS_WIDTH + 1;
	localparam int PPW     = AW + ROT_WIDTH;
	localparam int DPW     = DIR_WIDTH + ROT_WIDTH;
	localparam int PSW     = PPW + 2;
	localparam int DSW     = DPW + 2;
	localparam int RPW     = PSW - FRAC;
	localparam int RDW     = DSW - FRAC;

	localparam logic [PSW-1:0] P_HALF = PSW'(1) << (FRAC - 1);
	localparam logic [DSW-1:0] D_HALF = DSW'(1) << (FRAC - 1);
	localparam logic signed [RPW:0]   P_MAX = (RPW+1)'({1'b0, {(POS_WIDTH-1){1'b1}}});
	localparam logic signed [RPW:0]   P_MIN = -P_MAX - (RPW+1)'(1);
	localparam logic signed [RDW-1:0] D_MAX = RDW'({1'b0, {(DIR_WIDTH-1){1'b1}}});
	localparam logic signed [RDW-1:0] D_MIN = -D_MAX - RDW'(1);

	// configuration registers
	logic [ROWW-1:0]             rot_q [3];
	logic signed [POS_WIDTH-1:0] off_q [3];
	rrft_pkg::reg_idx_t          cfg_idx;
	logic                        cfg_wr;

	assign pready  = 1'b1;
	assign cfg_idx = rrft_pkg::reg_idx_t'(paddr[5:3]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_q[0] <= ROWW'(64'd65536);
			rot_q[1] <= ROWW'(64'd4294967296);
			rot_q[2] <= ROWW'(64'd281474976710656);
			off_q[0] <= '0;
			off_q[1] <= '0;
			off_q[2] <= '0;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				rrft_pkg::REG_ROT_ROW0: rot_q[0] <= pwdata[ROWW-1:0];
				rrft_pkg::REG_ROT_ROW1: rot_q[1] <= pwdata[ROWW-1:0];
				rrft_pkg::REG_ROT_ROW2: rot_q[2] <= pwdata[ROWW-1:0];
				rrft_pkg::REG_OFFSET_X: off_q[0] <= $signed(pwdata[POS_WIDTH-1:0]);
				rrft_pkg::REG_OFFSET_Y: off_q[1] <= $signed(pwdata[POS_WIDTH-1:0]);
				rrft_pkg::REG_OFFSET_Z: off_q[2] <= $signed(pwdata[POS_WIDTH-1:0]);
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			rrft_pkg::REG_ROT_ROW0: prdata = rrft_pkg::CFG_DATA_W'(rot_q[0]);
			rrft_pkg::REG_ROT_ROW1: prdata = rrft_pkg::CFG_DATA_W'(rot_q[1]);
			rrft_pkg::REG_ROT_ROW2: prdata = rrft_pkg::CFG_DATA_W'(rot_q[2]);
			rrft_pkg::REG_OFFSET_X: prdata = rrft_pkg::CFG_DATA_W'($unsigned(off_q[0]));
			rrft_pkg::REG_OFFSET_Y: prdata = rrft_pkg::CFG_DATA_W'($unsigned(off_q[1]));
			rrft_pkg::REG_OFFSET_Z: prdata = rrft_pkg::CFG_DATA_W'($unsigned(off_q[2]));
			default:                prdata = '0;
		endcase
	end

	// stage handshake
	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy1, rdy2, rdy3, rdy4;

	assign rdy4     = !v_s4 || m_tready;
	assign rdy3     = !v_s3 || rdy4;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign s_tready = rdy1;
	assign m_tvalid = v_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= s_tvalid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	// input unpacking
	logic signed [POS_WIDTH-1:0] in_pos [3];
	logic signed [DIR_WIDTH-1:0] in_dir [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			in_pos[i] = $signed(s_tdata[PX_LO + i*POS_WIDTH +: POS_WIDTH]);
			in_dir[i] = $signed(s_tdata[DX_LO + i*DIR_WIDTH +: DIR_WIDTH]);
		end
	end

	// passthrough fields; time, wavelength and flags reach stage 4, the rest stage 3
	logic signed [POS_WIDTH-1:0] pos_s1 [3], pos_s2 [3], pos_s3 [3];
	logic signed [DIR_WIDTH-1:0] dir_s1 [3], dir_s2 [3], dir_s3 [3];
	logic [WW-1:0]               tm_s1, tm_s2, tm_s3, tm_s4;
	logic [WW-1:0]               wv_s1, wv_s2, wv_s3, wv_s4;
	logic                        vg_s1, vg_s2, vg_s3, vg_s4;
	logic                        fl_s1, fl_s2, fl_s3, fl_s4;
	logic                        cmd_s1, cmd_s2, cmd_s3;

	// stage 1: operand setup
	logic signed [AW-1:0] a_s1 [3];

	always_ff @(posedge clk) begin
		if (rdy1 && s_tvalid) begin
			for (int i = 0; i < 3; i++) begin
				pos_s1[i] <= in_pos[i];
				dir_s1[i] <= in_dir[i];
				a_s1[i]   <= (s_tuser == rrft_pkg::CMD_REV) ? AW'(in_pos[i])
				                                            : AW'(in_pos[i]) - AW'(off_q[i]);
			end
			cmd_s1 <= s_tuser;
			tm_s1  <= s_tdata[TM_LO +: WW];
			wv_s1  <= s_tdata[WV_LO +: WW];
			vg_s1  <= s_tdata[VG_BIT];
			fl_s1  <= s_tdata[FL_BIT];
		end
	end

	// stage 2: products
	logic signed [ROT_WIDTH-1:0] coef [3][3];
	logic signed [PPW-1:0]       pp_s2 [3][3];
	logic signed [DPW-1:0]       dp_s2 [3][3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				coef[i][j] = (cmd_s1 == rrft_pkg::CMD_REV)
				           ? $signed(rot_q[i][j*ROT_WIDTH +: ROT_WIDTH])
				           : $signed(rot_q[j][i*ROT_WIDTH +: ROT_WIDTH]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					pp_s2[i][j] <= a_s1[j] * coef[i][j];
					dp_s2[i][j] <= dir_s1[j] * coef[i][j];
				end
				pos_s2[i] <= pos_s1[i];
				dir_s2[i] <= dir_s1[i];
			end
			cmd_s2 <= cmd_s1;
			tm_s2  <= tm_s1;
			wv_s2  <= wv_s1;
			vg_s2  <= vg_s1;
			fl_s2  <= fl_s1;
		end
	end

	// stage 3: sum and round to nearest, ties upward
	logic signed [PSW-1:0] psum [3];
	logic signed [DSW-1:0] dsum [3];
	logic signed [RPW-1:0] rp_s3 [3];
	logic signed [RDW-1:0] rd_s3 [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			psum[i] = PSW'(pp_s2[i][0]) + PSW'(pp_s2[i][1]) + PSW'(pp_s2[i][2])
			        + $signed(P_HALF);
			dsum[i] = DSW'(dp_s2[i][0]) + DSW'(dp_s2[i][1]) + DSW'(dp_s2[i][2])
			        + $signed(D_HALF);
		end
	end

	always_ff @(posedge clk) begin
		if (rdy3 && v_s2) begin
			for (int i = 0; i < 3; i++) begin
				rp_s3[i]  <= $signed(psum[i][PSW-1:FRAC]);
				rd_s3[i]  <= $signed(dsum[i][DSW-1:FRAC]);
				pos_s3[i] <= pos_s2[i];
				dir_s3[i] <= dir_s2[i];
			end
			cmd_s3 <= cmd_s2;
			tm_s3  <= tm_s2;
			wv_s3  <= wv_s2;
			vg_s3  <= vg_s2;
			fl_s3  <= fl_s2;
		end
	end

	// stage 4: offset, saturation, failed-ray bypass
	logic signed [RPW:0]         pext [3];
	logic signed [POS_WIDTH-1:0] psat [3];
	logic signed [DIR_WIDTH-1:0] dsat [3];
	logic signed [POS_WIDTH-1:0] opos_s4 [3];
	logic signed [DIR_WIDTH-1:0] odir_s4 [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			pext[i] = (cmd_s3 == rrft_pkg::CMD_REV)
			        ? (RPW+1)'(rp_s3[i]) + (RPW+1)'(off_q[i])
			        : (RPW+1)'(rp_s3[i]);
			if (pext[i] > P_MAX)
				psat[i] = P_MAX[POS_WIDTH-1:0];
			else if (pext[i] < P_MIN)
				psat[i] = P_MIN[POS_WIDTH-1:0];
			else
				psat[i] = pext[i][POS_WIDTH-1:0];
			if (rd_s3[i] > D_MAX)
				dsat[i] = D_MAX[DIR_WIDTH-1:0];
			else if (rd_s3[i] < D_MIN)
				dsat[i] = D_MIN[DIR_WIDTH-1:0];
			else
				dsat[i] = rd_s3[i][DIR_WIDTH-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy4 && v_s3) begin
			for (int i = 0; i < 3; i++) begin
				opos_s4[i] <= fl_s3 ? pos_s3[i] : psat[i];
				odir_s4[i] <= fl_s3 ? dir_s3[i] : dsat[i];
			end
			tm_s4 <= tm_s3;
			wv_s4 <= wv_s3;
			vg_s4 <= vg_s3;
			fl_s4 <= fl_s3;
		end
	end

	assign m_tdata = TD_W'({fl_s4, vg_s4, wv_s4, tm_s4,
	                        odir_s4[2], odir_s4[1], odir_s4[0],
	                        opos_s4[2], opos_s4[1], opos_s4[0]});

	logic fail_adv;

	assign fail_adv = v_s3 && rdy4 && fl_s3;

	`ASSERT_IMPL(a_stall_from_output, clk, arst_n, !s_tready, m_tvalid && !m_tready, "stall")
	`ASSERT_NEXT(a_stage_advance, clk, arst_n, v_s1 && rdy2, v_s2, "stage 2 item lost")
	`ASSERT_NEXT(a_failed_bypass, clk, arst_n, fail_adv, opos_s4[0] == $past(pos_s3[0]), "bypass")

endmodule

`default_nettype wire
